// ===== design/gpio_bank_pkg.sv =====
// shared types, codes and constants for the gpio bank
package gpio_bank_pkg;

  localparam int unsigned PIN_COUNT_DEF = 32;
  localparam int unsigned HALF_BITS     = 16;
  localparam int unsigned WORD_BITS     = 2 * HALF_BITS;
  localparam int unsigned INDEX_BITS    = 5;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  // half register groups, selected by reg_index[3:1]
  localparam logic [2:0] GRP_DATA  = 3'd0;
  localparam logic [2:0] GRP_DIR   = 3'd1;
  localparam logic [2:0] GRP_IEN   = 3'd2;
  localparam logic [2:0] GRP_MASK  = 3'd3;
  localparam logic [2:0] GRP_TYPE  = 3'd4;
  localparam logic [2:0] GRP_POL   = 3'd5;
  localparam logic [2:0] GRP_BOTH  = 3'd6;
  localparam logic [2:0] GRP_EOI   = 3'd7;

  localparam logic [INDEX_BITS-1:0] REG_STATUS  = 5'd16;
  localparam logic [INDEX_BITS-1:0] REG_RAW     = 5'd17;
  localparam logic [INDEX_BITS-1:0] REG_EXT     = 5'd18;
  localparam logic [INDEX_BITS-1:0] REG_VERSION = 5'd19;

  typedef struct packed {
    logic [1:0]            command;
    logic [INDEX_BITS-1:0] reg_index;
    logic [WORD_BITS-1:0]  write_data;
    logic [WORD_BITS-1:0]  pin_levels;
  } req_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] read_data;
    logic                 irq;
    logic [WORD_BITS-1:0] pin_drive;
    logic [WORD_BITS-1:0] pin_drive_enable;
  } res_t;

endpackage

// ===== design/gpio_bank_ifs.sv =====
// valid/ready channel interfaces for the gpio bank
interface gpio_bank_in_if;
  import gpio_bank_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            command;
  logic [INDEX_BITS-1:0] reg_index;
  logic [WORD_BITS-1:0]  write_data;
  logic [WORD_BITS-1:0]  pin_levels;

  modport source (output valid, output command, output reg_index, output write_data,
                  output pin_levels, input ready);
  modport sink (input valid, input command, input reg_index, input write_data,
                input pin_levels, output ready);
endinterface

interface gpio_bank_out_if;
  import gpio_bank_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] read_data;
  logic                 irq;
  logic [WORD_BITS-1:0] pin_drive;
  logic [WORD_BITS-1:0] pin_drive_enable;

  modport source (output valid, output read_data, output irq, output pin_drive,
                  output pin_drive_enable, input ready);
  modport sink (input valid, input read_data, input irq, input pin_drive,
                input pin_drive_enable, output ready);
endinterface

// ===== design/gpio_bank_regs.sv =====
// gpio bank register file, edge latching, status and read mux
module gpio_bank_regs #(
  parameter int unsigned PIN_COUNT = gpio_bank_pkg::PIN_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 take,
  input  gpio_bank_pkg::req_t                  req,
  input  logic                                 cfg_wr_en,
  input  logic [gpio_bank_pkg::WORD_BITS-1:0]  cfg_wr_data,
  output gpio_bank_pkg::res_t                  res
);
  import gpio_bank_pkg::*;

  typedef logic [PIN_COUNT-1:0] pins_t;

  function automatic logic [WORD_BITS-1:0] widen(input pins_t v);
    logic [WORD_BITS-1:0] w;
    w = '0;
    w[PIN_COUNT-1:0] = v;
    return w;
  endfunction

  pins_t data_r, dir_r, ien_r, msk_r, typ_r, pol_r, both_r, pend_r, last_r;
  pins_t data_nxt, dir_nxt, ien_nxt, msk_nxt, typ_nxt, pol_nxt, both_nxt, pend_nxt, last_nxt;
  logic [WORD_BITS-1:0] version_r;

  logic [WORD_BITS-1:0] wr_en_w, wr_dat_w;
  pins_t wr_en, wr_dat;
  pins_t now, rise, fall, hit;
  pins_t lvl, raw, stat;
  logic [WORD_BITS-1:0] half_sel, rd;

  assign wr_en_w  = req.reg_index[0] ? {req.write_data[WORD_BITS-1:HALF_BITS], {HALF_BITS{1'b0}}}
                                     : {{HALF_BITS{1'b0}}, req.write_data[WORD_BITS-1:HALF_BITS]};
  assign wr_dat_w = req.reg_index[0] ? {req.write_data[HALF_BITS-1:0], {HALF_BITS{1'b0}}}
                                     : {{HALF_BITS{1'b0}}, req.write_data[HALF_BITS-1:0]};
  assign wr_en    = wr_en_w[PIN_COUNT-1:0];
  assign wr_dat   = wr_dat_w[PIN_COUNT-1:0];

  // edge detect against the previous sample
  assign now  = req.pin_levels[PIN_COUNT-1:0];
  assign rise = now & ~last_r;
  assign fall = ~now & last_r;
  assign hit  = (both_r & (rise | fall)) | (~both_r & ((pol_r & rise) | (~pol_r & fall)));

  always_comb begin
    data_nxt = data_r;
    dir_nxt  = dir_r;
    ien_nxt  = ien_r;
    msk_nxt  = msk_r;
    typ_nxt  = typ_r;
    pol_nxt  = pol_r;
    both_nxt = both_r;
    pend_nxt = pend_r;
    last_nxt = last_r;
    if (take) begin
      case (cmd_t'(req.command))
        CMD_WRITE: begin
          if (!req.reg_index[INDEX_BITS-1]) begin
            case (req.reg_index[3:1])
              GRP_DATA: data_nxt = (data_r & ~wr_en) | (wr_dat & wr_en);
              GRP_DIR:  dir_nxt  = (dir_r  & ~wr_en) | (wr_dat & wr_en);
              GRP_IEN:  ien_nxt  = (ien_r  & ~wr_en) | (wr_dat & wr_en);
              GRP_MASK: msk_nxt  = (msk_r  & ~wr_en) | (wr_dat & wr_en);
              GRP_TYPE: typ_nxt  = (typ_r  & ~wr_en) | (wr_dat & wr_en);
              GRP_POL:  pol_nxt  = (pol_r  & ~wr_en) | (wr_dat & wr_en);
              GRP_BOTH: both_nxt = (both_r & ~wr_en) | (wr_dat & wr_en);
              GRP_EOI:  pend_nxt = pend_r & ~(wr_en & wr_dat);
              default: ;
            endcase
          end
        end
        CMD_TICK: begin
          pend_nxt = pend_r | (hit & ien_r & typ_r);
          last_nxt = now;
        end
        default: ;
      endcase
    end
  end

  // status from the updated state
  assign lvl  = (pol_nxt & last_nxt) | (~pol_nxt & ~last_nxt);
  assign raw  = ien_nxt & ((~typ_nxt & lvl) | pend_nxt);
  assign stat = raw & ~msk_nxt;

  always_comb begin
    case (req.reg_index[3:1])
      GRP_DATA: half_sel = widen(data_nxt);
      GRP_DIR:  half_sel = widen(dir_nxt);
      GRP_IEN:  half_sel = widen(ien_nxt);
      GRP_MASK: half_sel = widen(msk_nxt);
      GRP_TYPE: half_sel = widen(typ_nxt);
      GRP_POL:  half_sel = widen(pol_nxt);
      GRP_BOTH: half_sel = widen(both_nxt);
      default:  half_sel = '0;
    endcase
  end

  always_comb begin
    rd = '0;
    if (!req.reg_index[INDEX_BITS-1]) begin
      rd[HALF_BITS-1:0] = req.reg_index[0] ? half_sel[WORD_BITS-1:HALF_BITS]
                                           : half_sel[HALF_BITS-1:0];
    end else begin
      case (req.reg_index)
        REG_STATUS:  rd = widen(stat);
        REG_RAW:     rd = widen(raw);
        REG_EXT:     rd = widen(last_nxt);
        REG_VERSION: rd = version_r;
        default:     rd = '0;
      endcase
    end
  end

  assign res.read_data        = (cmd_t'(req.command) == CMD_READ) ? rd : '0;
  assign res.irq              = |stat;
  assign res.pin_drive        = widen(data_nxt);
  assign res.pin_drive_enable = widen(dir_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r    <= '0;
      dir_r     <= '0;
      ien_r     <= '0;
      msk_r     <= '0;
      typ_r     <= '0;
      pol_r     <= '0;
      both_r    <= '0;
      pend_r    <= '0;
      last_r    <= '0;
      version_r <= '0;
    end else begin
      data_r <= data_nxt;
      dir_r  <= dir_nxt;
      ien_r  <= ien_nxt;
      msk_r  <= msk_nxt;
      typ_r  <= typ_nxt;
      pol_r  <= pol_nxt;
      both_r <= both_nxt;
      pend_r <= pend_nxt;
      last_r <= last_nxt;
      if (cfg_wr_en) begin
        version_r <= cfg_wr_data;
      end
    end
  end

  // pending edges only appear on enabled edge-typed pins
  a_pend_source: assert property (@(posedge clk) disable iff (!rst_n)
    (take && cmd_t'(req.command) == CMD_TICK) |=>
      ((pend_r & ~$past(pend_r)) & ~($past(ien_r) & $past(typ_r))) == '0)
    else $error("edge latched on a pin not enabled for edges");

  a_sample_kept: assert property (@(posedge clk) disable iff (!rst_n)
    !(take && cmd_t'(req.command) == CMD_TICK) |=> $stable(last_r))
    else $error("pin sample changed without a tick");

endmodule

// ===== design/gpio_bank_skid.sv =====
// two-word result buffer between the register file and the result channel
module gpio_bank_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  gpio_bank_pkg::res_t  push_data,
  output logic                 push_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gpio_bank_pkg::res_t  out_data
);
  import gpio_bank_pkg::*;

  res_t head_r, spare_r;
  logic head_v_r, spare_v_r;
  logic pop;

  assign pop        = head_v_r && out_ready;
  assign push_ready = !spare_v_r;
  assign out_valid  = head_v_r;
  assign out_data   = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r  <= 1'b0;
      spare_v_r <= 1'b0;
    end else begin
      if (pop || !head_v_r) begin
        if (spare_v_r) begin
          head_v_r  <= 1'b1;
          spare_v_r <= 1'b0;
        end else begin
          head_v_r <= push;
        end
      end else if (push) begin
        spare_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !head_v_r) begin
      head_r <= spare_v_r ? spare_r : push_data;
    end else if (push) begin
      spare_r <= push_data;
    end
  end

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    spare_v_r |-> head_v_r)
    else $error("spare word held with empty head");

  a_spill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && head_v_r && !out_ready) |=> spare_v_r && $stable(head_r))
    else $error("stalled word lost on push");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (spare_v_r && out_ready) |=> (head_v_r && head_r == $past(spare_r)))
    else $error("spare word not moved to head");

endmodule

// ===== design/gpio_bank_with_masked_writes_and_irq_unit.sv =====
// top level of the 32-pin gpio bank with masked half writes and interrupt logic
// One bus write, bus read or pin sample tick is accepted per clock while input ready is
// high; it drops only when two results are buffered. The result word (read data, irq, pin
// drive, drive enable after the update) is registered in the buffer head, or its spare word
// while the head waits. The rate is set by the combinational update path from a half
// write through the status OR. Write the version register via cfg_wr_en/cfg_wr_data only
// while the bank is idle; this is not enforced. Pins at or above PIN_COUNT read 0.
module gpio_bank_with_masked_writes_and_irq_unit #(
  parameter int unsigned PIN_COUNT = gpio_bank_pkg::PIN_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  gpio_bank_in_if.sink                        in_ch,
  gpio_bank_out_if.source                     out_ch,
  input  logic                                cfg_wr_en,
  input  logic [gpio_bank_pkg::WORD_BITS-1:0] cfg_wr_data
);
  import gpio_bank_pkg::*;

  req_t req;
  res_t res, out_word;
  logic take, buf_ready;

  assign req.command    = in_ch.command;
  assign req.reg_index  = in_ch.reg_index;
  assign req.write_data = in_ch.write_data;
  assign req.pin_levels = in_ch.pin_levels;

  assign in_ch.ready = buf_ready;
  assign take        = in_ch.valid && buf_ready;

  gpio_bank_regs #(
    .PIN_COUNT (PIN_COUNT)
  ) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .req         (req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res         (res)
  );

  gpio_bank_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (take),
    .push_data  (res),
    .push_ready (buf_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_word)
  );

  assign out_ch.read_data        = out_word.read_data;
  assign out_ch.irq              = out_word.irq;
  assign out_ch.pin_drive        = out_word.pin_drive;
  assign out_ch.pin_drive_enable = out_word.pin_drive_enable;

endmodule
